[rtl/gre_pkg.sv]
// ---------------------------------------------------------------------------
// Graph reachability engine package
// Field widths, operation codes and the classified command passed from the
// front end to the back end.
// ---------------------------------------------------------------------------
`default_nettype none

package gre_pkg;

  localparam int OP_W        = 3;
  localparam int GSEL_W      = 1;
  localparam int NODE_W      = 6;
  localparam int MASK_W      = 64;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [OP_W-1:0] {
    OP_ADD  = 3'd0,
    OP_FWD  = 3'd1,
    OP_BWD  = 3'd2,
    OP_PAIR = 3'd3,
    OP_CLR  = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    K_NOP,
    K_ADD,
    K_QUERY,
    K_CLR
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic              backward;
    logic              pair;
    logic              dst_ok;
    logic [GSEL_W-1:0] graph;
    logic [NODE_W-1:0] start;
    logic [NODE_W-1:0] dst;
  } cmd_t;

endpackage

`default_nettype wire

[rtl/gre_if.sv]
// ---------------------------------------------------------------------------
// Graph reachability engine channels
// Valid/ready channels for command and result transactions.
// ---------------------------------------------------------------------------
`default_nettype none

interface gre_cmd_if;
  logic                        valid;
  logic                        ready;
  logic [gre_pkg::OP_W-1:0]    op;
  logic [gre_pkg::GSEL_W-1:0]  graph_sel;
  logic [gre_pkg::NODE_W-1:0]  src_node;
  logic [gre_pkg::NODE_W-1:0]  dst_node;

  modport source (output valid, op, graph_sel, src_node, dst_node, input ready);
  modport sink   (input valid, op, graph_sel, src_node, dst_node, output ready);
endinterface

interface gre_res_if;
  logic                        valid;
  logic                        ready;
  logic [gre_pkg::MASK_W-1:0]  reach_mask;
  logic                        found;

  modport source (output valid, reach_mask, found, input ready);
  modport sink   (input valid, reach_mask, found, output ready);
endinterface

`default_nettype wire

[rtl/gre_ram.sv]
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module gre_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

[rtl/gre_front.sv]
// ---------------------------------------------------------------------------
// Graph reachability engine front end
// Accepts command transactions, checks graph and node ranges, and queues the
// classified commands for the back end.
// ---------------------------------------------------------------------------
`default_nettype none

module gre_front #(
  parameter int NODE_COUNT  = 64,
  parameter int GRAPH_COUNT = 2
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  gre_cmd_if.sink     cmd_i,
  output gre_pkg::cmd_t q_cmd_o,
  output logic        q_valid_o,
  input  wire logic   q_ready_i
);

  localparam int QPW  = $clog2(gre_pkg::QUEUE_DEPTH);
  localparam int CNTW = $clog2(gre_pkg::QUEUE_DEPTH + 1);

  gre_pkg::cmd_t   queue_q [gre_pkg::QUEUE_DEPTH];
  logic [QPW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  gre_pkg::cmd_t   cls;
  logic            g_ok, s_ok, d_ok;
  logic            push, pop;

  assign g_ok = {1'b0, cmd_i.graph_sel} < 2'(GRAPH_COUNT);
  assign s_ok = {1'b0, cmd_i.src_node} < 7'(NODE_COUNT);
  assign d_ok = {1'b0, cmd_i.dst_node} < 7'(NODE_COUNT);

  always_comb begin
    cls          = '0;
    cls.kind     = gre_pkg::K_NOP;
    cls.graph    = cmd_i.graph_sel;
    cls.start    = cmd_i.src_node;
    cls.dst      = cmd_i.dst_node;
    cls.dst_ok   = d_ok;
    case (gre_pkg::op_e'(cmd_i.op))
      gre_pkg::OP_ADD: begin
        if (g_ok && s_ok && d_ok) cls.kind = gre_pkg::K_ADD;
      end
      gre_pkg::OP_FWD: begin
        if (g_ok && s_ok) cls.kind = gre_pkg::K_QUERY;
      end
      gre_pkg::OP_BWD: begin
        cls.backward = 1'b1;
        cls.start    = cmd_i.dst_node;
        if (g_ok && d_ok) cls.kind = gre_pkg::K_QUERY;
      end
      gre_pkg::OP_PAIR: begin
        cls.pair = 1'b1;
        if (g_ok && s_ok) cls.kind = gre_pkg::K_QUERY;
      end
      gre_pkg::OP_CLR: begin
        if (g_ok) cls.kind = gre_pkg::K_CLR;
      end
      default: begin
        cls.kind = gre_pkg::K_NOP;
      end
    endcase
  end

  assign cmd_i.ready = cnt_q != CNTW'(gre_pkg::QUEUE_DEPTH);
  assign push        = cmd_i.valid && cmd_i.ready;
  assign q_valid_o   = cnt_q != '0;
  assign pop         = q_valid_o && q_ready_i;
  assign q_cmd_o     = queue_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= cls;
    end
  end

endmodule

`default_nettype wire

[rtl/gre_back.sv]
// ---------------------------------------------------------------------------
// Graph reachability engine back end
// Holds the successor and predecessor row memories, executes edge insertion,
// graph clearing and frontier expansion, and drives the result register.
// ---------------------------------------------------------------------------
`default_nettype none

module gre_back #(
  parameter int NODE_COUNT  = 64,
  parameter int GRAPH_COUNT = 2
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire gre_pkg::cmd_t         cmd_i,
  input  wire logic                  cmd_valid_i,
  output logic                       cmd_ready_o,
  output logic                       res_valid_o,
  input  wire logic                  res_ready_i,
  output logic [NODE_COUNT-1:0]      res_mask_o,
  output logic                       res_found_o
);

  localparam int NW    = $clog2(NODE_COUNT);
  localparam int AW    = $clog2(GRAPH_COUNT * NODE_COUNT);
  localparam int DEPTH = 1 << AW;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ADD_WR,
    S_EXPAND,
    S_DONE
  } state_e;

  function automatic logic [AW-1:0] row_addr(input logic g, input logic [NW-1:0] n);
    return g ? AW'(NODE_COUNT) + AW'(n) : AW'(n);
  endfunction

  function automatic logic [NODE_COUNT-1:0] node_bit(input logic [NW-1:0] n);
    return {{(NODE_COUNT-1){1'b0}}, 1'b1} << n;
  endfunction

  function automatic logic [NW-1:0] first_set(input logic [NODE_COUNT-1:0] v);
    logic [NW-1:0] idx;
    idx = '0;
    for (int i = NODE_COUNT - 1; i >= 0; i--) begin
      if (v[i]) idx = NW'(i);
    end
    return idx;
  endfunction

  state_e                 state_q, state_d;
  gre_pkg::cmd_t          cmd_q, cmd_d;
  logic [NODE_COUNT-1:0]  reach_q, reach_d;
  logic [NODE_COUNT-1:0]  pend_q, pend_d;
  logic                   infl_q, infl_d;
  logic                   rvs_q, rvp_q;
  logic [DEPTH-1:0]       svld_q, svld_d;
  logic [DEPTH-1:0]       pvld_q, pvld_d;
  logic                   out_valid_q, out_valid_d;
  logic [NODE_COUNT-1:0]  out_mask_q, out_mask_d;
  logic                   out_found_q, out_found_d;

  logic                   s_we, p_we;
  logic [AW-1:0]          s_waddr, p_waddr, s_raddr, p_raddr;
  logic [NODE_COUNT-1:0]  s_wdata, p_wdata, s_rdata, p_rdata;
  logic [NODE_COUNT-1:0]  srow, prow, qrow, new_bits;
  logic [NW-1:0]          pick;

  gre_ram #(.WIDTH(NODE_COUNT), .DEPTH(DEPTH)) u_succ_ram (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (s_waddr),
    .wdata_i (s_wdata),
    .raddr_i (s_raddr),
    .rdata_o (s_rdata)
  );

  gre_ram #(.WIDTH(NODE_COUNT), .DEPTH(DEPTH)) u_pred_ram (
    .clk_i   (clk_i),
    .we_i    (p_we),
    .waddr_i (p_waddr),
    .wdata_i (p_wdata),
    .raddr_i (p_raddr),
    .rdata_o (p_rdata)
  );

  assign srow     = rvs_q ? s_rdata : '0;
  assign prow     = rvp_q ? p_rdata : '0;
  assign qrow     = cmd_q.backward ? prow : srow;
  assign new_bits = infl_q ? qrow : '0;
  assign pick     = first_set(pend_q);

  assign cmd_ready_o = state_q == S_IDLE;
  assign res_valid_o = out_valid_q;
  assign res_mask_o  = out_mask_q;
  assign res_found_o = out_found_q;

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    reach_d     = reach_q;
    pend_d      = pend_q;
    infl_d      = 1'b0;
    svld_d      = svld_q;
    pvld_d      = pvld_q;
    out_valid_d = out_valid_q && !res_ready_i;
    out_mask_d  = out_mask_q;
    out_found_d = out_found_q;
    s_raddr     = '0;
    p_raddr     = '0;
    s_we        = 1'b0;
    p_we        = 1'b0;
    s_waddr     = row_addr(cmd_q.graph, cmd_q.start[NW-1:0]);
    p_waddr     = row_addr(cmd_q.graph, cmd_q.dst[NW-1:0]);
    s_wdata     = srow | node_bit(cmd_q.dst[NW-1:0]);
    p_wdata     = prow | node_bit(cmd_q.start[NW-1:0]);

    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_d = cmd_i;
          case (cmd_i.kind)
            gre_pkg::K_ADD: begin
              s_raddr = row_addr(cmd_i.graph, cmd_i.start[NW-1:0]);
              p_raddr = row_addr(cmd_i.graph, cmd_i.dst[NW-1:0]);
              state_d = S_ADD_WR;
            end
            gre_pkg::K_QUERY: begin
              s_raddr = row_addr(cmd_i.graph, cmd_i.start[NW-1:0]);
              p_raddr = s_raddr;
              infl_d  = 1'b1;
              reach_d = '0;
              pend_d  = '0;
              state_d = S_EXPAND;
            end
            gre_pkg::K_CLR: begin
              for (int r = 0; r < DEPTH; r++) begin
                if ((r >= NODE_COUNT) == (cmd_i.graph == 1'b1)) begin
                  svld_d[r] = 1'b0;
                  pvld_d[r] = 1'b0;
                end
              end
              state_d = S_DONE;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_ADD_WR: begin
        s_we            = 1'b1;
        p_we            = 1'b1;
        svld_d[s_waddr] = 1'b1;
        pvld_d[p_waddr] = 1'b1;
        state_d         = S_DONE;
      end
      S_EXPAND: begin
        reach_d = reach_q | new_bits;
        pend_d  = pend_q | (new_bits & ~reach_q);
        if (pend_q != '0) begin
          pend_d  = (pend_q & ~node_bit(pick)) | (new_bits & ~reach_q);
          s_raddr = row_addr(cmd_q.graph, pick);
          p_raddr = s_raddr;
          infl_d  = 1'b1;
        end else if (!infl_q) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || res_ready_i) begin
          out_valid_d = 1'b1;
          if (cmd_q.kind == gre_pkg::K_QUERY) begin
            out_mask_d  = reach_q;
            out_found_d = cmd_q.pair ? (cmd_q.dst_ok && reach_q[cmd_q.dst[NW-1:0]])
                                     : (reach_q != '0);
          end else begin
            out_mask_d  = '0;
            out_found_d = 1'b0;
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cmd_q       <= '0;
      reach_q     <= '0;
      pend_q      <= '0;
      infl_q      <= 1'b0;
      rvs_q       <= 1'b0;
      rvp_q       <= 1'b0;
      svld_q      <= '0;
      pvld_q      <= '0;
      out_valid_q <= 1'b0;
      out_mask_q  <= '0;
      out_found_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cmd_q       <= cmd_d;
      reach_q     <= reach_d;
      pend_q      <= pend_d;
      infl_q      <= infl_d;
      rvs_q       <= svld_q[s_raddr];
      rvp_q       <= pvld_q[p_raddr];
      svld_q      <= svld_d;
      pvld_q      <= pvld_d;
      out_valid_q <= out_valid_d;
      out_mask_q  <= out_mask_d;
      out_found_q <= out_found_d;
    end
  end

endmodule

`default_nettype wire

[rtl/graph_reachability_engine_core.sv]
// ---------------------------------------------------------------------------
// Graph reachability engine
// Stores directed graphs as successor rows and answers transitive
// reachability queries over them.
// ---------------------------------------------------------------------------
// Each command transaction adds an edge, clears a graph, or asks for the
// forward set of a source node, the backward set of a destination node, or
// whether the destination is reachable from the source; every command yields
// exactly one result transaction. A query expands its frontier one node per
// cycle while found nodes wait, reading that node's row from the successor
// memory (forward and pair queries) or from the predecessor memory
// (backward queries). A node found while others still wait is expanded in
// the next cycle, but once the waiting set has run dry the expansion waits
// for the outstanding row read. A chain through every node therefore takes
// the most time. An edge insertion reads the successor and predecessor rows
// and then writes both back with the new edge. The back end waits to finish
// a command while an earlier result is not yet accepted. A two-entry command
// queue and the result register let new commands be accepted while the back
// end works or a result waits. Per-row valid flags make reset and clear
// immediate, with no memory sweep.
// ---------------------------------------------------------------------------
`default_nettype none

module graph_reachability_engine_core #(
  parameter int NODE_COUNT  = 64,
  parameter int GRAPH_COUNT = 2
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  gre_cmd_if.sink    cmd_i,
  gre_res_if.source  res_o
);

  localparam int MASK_W = gre_pkg::MASK_W;
  localparam int OUT_MAX = gre_pkg::QUEUE_DEPTH + 2;
  localparam int OUTW    = $clog2(OUT_MAX + 1);

  gre_pkg::cmd_t         q_cmd;
  logic                  q_valid, q_ready;
  logic [NODE_COUNT-1:0] res_mask;
  logic                  res_found;
  logic [OUTW-1:0]       outst_q, outst_d;
  logic                  in_acc, out_acc;

  gre_front #(.NODE_COUNT(NODE_COUNT), .GRAPH_COUNT(GRAPH_COUNT)) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd_i),
    .q_cmd_o   (q_cmd),
    .q_valid_o (q_valid),
    .q_ready_i (q_ready)
  );

  gre_back #(.NODE_COUNT(NODE_COUNT), .GRAPH_COUNT(GRAPH_COUNT)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (q_cmd),
    .cmd_valid_i (q_valid),
    .cmd_ready_o (q_ready),
    .res_valid_o (res_o.valid),
    .res_ready_i (res_o.ready),
    .res_mask_o  (res_mask),
    .res_found_o (res_found)
  );

  assign res_o.reach_mask = MASK_W'(res_mask);
  assign res_o.found      = res_found;

  assign in_acc  = cmd_i.valid && cmd_i.ready;
  assign out_acc = res_o.valid && res_o.ready;

  always_comb begin
    outst_d = outst_q;
    if (in_acc && !out_acc) begin
      outst_d = outst_q + 1'b1;
    end else if (out_acc && !in_acc) begin
      outst_d = outst_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outst_q <= '0;
    end else begin
      outst_q <= outst_d;
    end
  end

  a_found_needs_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.found |-> res_o.reach_mask != '0)
    else $error("found set with an empty reach mask");

  a_outstanding_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    outst_q <= OUTW'(OUT_MAX))
    else $error("more transactions in flight than the engine can hold");

  a_result_has_command: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> outst_q != '0)
    else $error("result offered with no command outstanding");

endmodule

`default_nettype wire

[tb/gre_reach_checker.sv]
// ---------------------------------------------------------------------------
// Graph reachability result checker
// Watches the command and result channels of the reachability engine, keeps
// its own copy of both graphs, predicts the result of every accepted command
// and compares each accepted result with the oldest prediction.
// ---------------------------------------------------------------------------
`default_nettype none

module gre_reach_checker #(
  parameter int NODE_COUNT  = 64,
  parameter int GRAPH_COUNT = 2
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  gre_cmd_if        cmd_i,
  gre_res_if        res_i,
  output int        mismatch_count_o,
  output int        pending_o,
  output int        result_count_o,
  output int        found_count_o
);

  localparam int MASK_W = gre_pkg::MASK_W;

  localparam logic [MASK_W-1:0] NODE_MASK =
    (NODE_COUNT >= MASK_W) ? {MASK_W{1'b1}} : ((MASK_W'(1) << NODE_COUNT) - 1);

  typedef struct packed {
    logic [MASK_W-1:0] reach_mask;
    logic              found;
  } reach_result_t;

  logic [MASK_W-1:0] edge_rows [GRAPH_COUNT][NODE_COUNT];
  reach_result_t     expected_results [$];

  function automatic logic [MASK_W-1:0] reach_from(int g, int n);
    logic [MASK_W-1:0] reach;
    logic [MASK_W-1:0] grown;
    grown = edge_rows[g][n] & NODE_MASK;
    do begin
      reach = grown;
      for (int i = 0; i < NODE_COUNT; i++) begin
        if (reach[i]) grown |= edge_rows[g][i];
      end
      grown &= NODE_MASK;
    end while (grown != reach);
    return reach;
  endfunction

  function automatic logic [MASK_W-1:0] reach_into(int g, int n);
    logic [MASK_W-1:0] reach;
    logic [MASK_W-1:0] grown;
    grown = '0;
    for (int i = 0; i < NODE_COUNT; i++) begin
      if (edge_rows[g][i][n]) grown[i] = 1'b1;
    end
    do begin
      reach = grown;
      for (int i = 0; i < NODE_COUNT; i++) begin
        if ((edge_rows[g][i] & reach) != '0) grown[i] = 1'b1;
      end
      grown &= NODE_MASK;
    end while (grown != reach);
    return reach;
  endfunction

  function automatic reach_result_t predict_reach(logic [gre_pkg::OP_W-1:0] op, int g,
                                                  int s, int d);
    reach_result_t r;
    logic          s_ok;
    logic          d_ok;
    r    = '0;
    s_ok = s < NODE_COUNT;
    d_ok = d < NODE_COUNT;
    if (g >= GRAPH_COUNT) return r;
    case (op)
      gre_pkg::OP_ADD: begin
        if (s_ok && d_ok) edge_rows[g][s][d] = 1'b1;
      end
      gre_pkg::OP_FWD: begin
        if (s_ok) r.reach_mask = reach_from(g, s);
        r.found = r.reach_mask != '0;
      end
      gre_pkg::OP_BWD: begin
        if (d_ok) r.reach_mask = reach_into(g, d);
        r.found = r.reach_mask != '0;
      end
      gre_pkg::OP_PAIR: begin
        if (s_ok) r.reach_mask = reach_from(g, s);
        r.found = d_ok && r.reach_mask[d];
      end
      gre_pkg::OP_CLR: begin
        for (int i = 0; i < NODE_COUNT; i++) edge_rows[g][i] = '0;
      end
      default: begin
      end
    endcase
    r.reach_mask &= NODE_MASK;
    return r;
  endfunction

  task automatic report_mismatch(string what, reach_result_t want, reach_result_t got);
    mismatch_count_o++;
    if (mismatch_count_o <= 10) begin
      $display("[%0t] %s: expected mask %h found %b, got mask %h found %b", $realtime,
               what, want.reach_mask, want.found, got.reach_mask, got.found);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch_channels
    reach_result_t want;
    reach_result_t got;
    if (!rst_ni) begin
      foreach (edge_rows[g, n]) edge_rows[g][n] = '0;
      expected_results.delete();
      mismatch_count_o = 0;
      pending_o        = 0;
      result_count_o   = 0;
      found_count_o    = 0;
    end else begin
      if (cmd_i.valid && cmd_i.ready) begin
        expected_results.push_back(predict_reach(cmd_i.op, int'(cmd_i.graph_sel),
                                                 int'(cmd_i.src_node), int'(cmd_i.dst_node)));
      end
      if (res_i.valid && res_i.ready) begin
        got.reach_mask = res_i.reach_mask;
        got.found      = res_i.found;
        result_count_o++;
        if (got.found) found_count_o++;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result transaction", '0, got);
        end else begin
          want = expected_results.pop_front();
          if (got.reach_mask !== want.reach_mask || got.found !== want.found) begin
            report_mismatch("result mismatch", want, got);
          end
        end
      end
      pending_o = expected_results.size();
    end
  end

endmodule

`default_nettype wire

[tb/tb_top.sv]
// ---------------------------------------------------------------------------
// Graph reachability engine testbench
// Drives edge insertions, graph clears and reachability queries into the
// engine under random idling and a long result stall, and reports whether
// every result transaction matched the checker's prediction.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_top;

  localparam int NODE_COUNT   = 64;
  localparam int GRAPH_COUNT  = 2;
  localparam int RANDOM_ITEMS = 850;

  localparam logic [gre_pkg::OP_W-1:0] OP_UNUSED_LO = 3'd5;
  localparam logic [gre_pkg::OP_W-1:0] OP_UNUSED_HI = 3'd7;

  logic clk_i;
  logic rst_ni;
  bit   quiet_run;
  bit   hold_req;
  int   sent_count;
  int   mismatch_count;
  int   pending_count;
  int   result_count;
  int   found_count;

  gre_cmd_if cmd_bus ();
  gre_res_if res_bus ();

  graph_reachability_engine_core #(
    .NODE_COUNT (NODE_COUNT),
    .GRAPH_COUNT(GRAPH_COUNT)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd_bus),
    .res_o (res_bus)
  );

  gre_reach_checker #(
    .NODE_COUNT (NODE_COUNT),
    .GRAPH_COUNT(GRAPH_COUNT)
  ) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd_bus),
    .res_i           (res_bus),
    .mismatch_count_o(mismatch_count),
    .pending_o       (pending_count),
    .result_count_o  (result_count),
    .found_count_o   (found_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #800000;
    $display("CHECK FAILED");
    $finish;
  end

  // The receiver stalls at random, except in the quiet stretch, and holds off
  // for a long run of cycles once the stimulus asks for it.
  initial begin : drive_result_ready
    int hold_left;
    hold_left     = 0;
    res_bus.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        res_bus.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req       = 1'b0;
        hold_left      = 300;
        res_bus.ready <= 1'b0;
      end else begin
        res_bus.ready <= quiet_run || ($urandom_range(99) >= 17);
      end
    end
  end

  task automatic issue_cmd(logic [gre_pkg::OP_W-1:0] op, logic [gre_pkg::GSEL_W-1:0] g,
                           logic [gre_pkg::NODE_W-1:0] s, logic [gre_pkg::NODE_W-1:0] d);
    if (!quiet_run && $urandom_range(99) < 17) begin
      cmd_bus.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk_i);
    end
    cmd_bus.valid     <= 1'b1;
    cmd_bus.op        <= op;
    cmd_bus.graph_sel <= g;
    cmd_bus.src_node  <= s;
    cmd_bus.dst_node  <= d;
    @(posedge clk_i);
    while (!cmd_bus.ready) @(posedge clk_i);
    sent_count++;
    @(negedge clk_i);
  endtask

  initial begin : stimulus
    logic [gre_pkg::OP_W-1:0]   op;
    logic [gre_pkg::NODE_W-1:0] span;
    int                         pick;
    rst_ni            = 1'b0;
    quiet_run         = 1'b0;
    hold_req          = 1'b0;
    sent_count        = 0;
    cmd_bus.valid     = 1'b0;
    cmd_bus.op        = gre_pkg::OP_ADD;
    cmd_bus.graph_sel = '0;
    cmd_bus.src_node  = '0;
    cmd_bus.dst_node  = '0;
    span              = gre_pkg::NODE_W'(NODE_COUNT - 1);
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    issue_cmd(gre_pkg::OP_FWD, 1'b0, 6'd0, 6'd0);
    issue_cmd(gre_pkg::OP_ADD, 1'b0, 6'd0, 6'd63);
    issue_cmd(gre_pkg::OP_ADD, 1'b0, 6'd63, 6'd0);
    issue_cmd(gre_pkg::OP_ADD, 1'b0, 6'd0, 6'd63);
    issue_cmd(gre_pkg::OP_FWD, 1'b0, 6'd0, 6'd0);
    issue_cmd(gre_pkg::OP_BWD, 1'b0, 6'd0, 6'd63);
    issue_cmd(gre_pkg::OP_PAIR, 1'b0, 6'd0, 6'd63);
    issue_cmd(gre_pkg::OP_PAIR, 1'b0, 6'd63, 6'd5);
    issue_cmd(gre_pkg::OP_ADD, 1'b0, 6'd5, 6'd5);
    issue_cmd(gre_pkg::OP_FWD, 1'b0, 6'd5, 6'd0);
    issue_cmd(gre_pkg::OP_ADD, 1'b1, 6'd1, 6'd2);
    issue_cmd(gre_pkg::OP_ADD, 1'b1, 6'd2, 6'd3);
    issue_cmd(gre_pkg::OP_ADD, 1'b1, 6'd3, 6'd62);
    issue_cmd(gre_pkg::OP_FWD, 1'b1, 6'd1, 6'd0);
    issue_cmd(gre_pkg::OP_BWD, 1'b1, 6'd0, 6'd62);
    issue_cmd(gre_pkg::OP_PAIR, 1'b1, 6'd62, 6'd1);
    issue_cmd(gre_pkg::OP_FWD, 1'b0, 6'd1, 6'd0);
    for (int c = OP_UNUSED_LO; c <= OP_UNUSED_HI; c++) begin
      issue_cmd(gre_pkg::OP_W'(c), 1'b1, 6'd63, 6'd63);
    end
    issue_cmd(gre_pkg::OP_CLR, 1'b0, 6'd0, 6'd0);
    issue_cmd(gre_pkg::OP_FWD, 1'b0, 6'd0, 6'd0);
    issue_cmd(gre_pkg::OP_PAIR, 1'b1, 6'd1, 6'd62);
    issue_cmd(gre_pkg::OP_CLR, 1'b1, 6'd63, 6'd63);
    issue_cmd(gre_pkg::OP_BWD, 1'b1, 6'd0, 6'd62);

    // Node ranges are narrowed in bursts so that dense graphs with long
    // paths and cycles form, with clears now and then to start over.
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      quiet_run = (k >= 100) && (k < 250);
      if (k == 400) hold_req = 1'b1;
      if (k % 40 == 0) begin
        case ($urandom_range(3))
          0: span = 6'd7;
          1: span = 6'd15;
          2: span = 6'd31;
          default: span = 6'd63;
        endcase
      end
      pick = $urandom_range(99);
      if (pick < 2) op = gre_pkg::OP_CLR;
      else if (pick < 4) op = gre_pkg::OP_W'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
      else if (pick < 45) op = gre_pkg::OP_ADD;
      else if (pick < 60) op = gre_pkg::OP_FWD;
      else if (pick < 75) op = gre_pkg::OP_BWD;
      else op = gre_pkg::OP_PAIR;
      issue_cmd(op, gre_pkg::GSEL_W'($urandom_range(1)),
                gre_pkg::NODE_W'($urandom_range(span)),
                gre_pkg::NODE_W'($urandom_range(span)));
    end
    quiet_run      = 1'b0;
    cmd_bus.valid <= 1'b0;

    wait (pending_count == 0);
    repeat (150) @(negedge clk_i);
    $display("Run covered %0d command transactions and %0d result transactions, %0d with found set,",
             sent_count, result_count, found_count);
    $display("including edge adds, clears, all query kinds, unused codes and a long result stall.");
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
